>>> sv/tgl_pkg.sv
// Shared types, constants and functions of the theme gradient lookup block.
package tgl_pkg;

  localparam int STOP_N = 16;
  localparam int IDX_W = $clog2(STOP_N);
  localparam int CNT_W = $clog2(STOP_N + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = 2;

  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [8:0] TONE_UNITY = 9'd256;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_BRIGHTNESS = 3'd0,
    REG_KNEE_LEVEL      = 3'd1,
    REG_RAMP_BRIGHTNESS = 3'd2,
    REG_STOP_COUNT      = 3'd3,
    REG_UNIFORM_SPACING = 3'd4,
    REG_REVERSE_RAMP    = 3'd5
  } reg_e;

  typedef struct packed {
    logic [8:0]       tone_brightness;
    logic [7:0]       knee_level;
    logic [9:0]       ramp_brightness;
    logic [CNT_W-1:0] stop_count;
    logic             uniform_spacing;
    logic             reverse_ramp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tone_brightness: 9'd256,
    knee_level:      8'd255,
    ramp_brightness: 10'd256,
    stop_count:      CNT_W'(6),
    uniform_spacing: 1'b1,
    reverse_ramp:    1'b0
  };

  typedef struct packed {
    cmd_e       command;
    logic [3:0] stop_index;
    logic [7:0] stop_red;
    logic [7:0] stop_green;
    logic [7:0] stop_blue;
    logic [7:0] stop_position;
    logic [7:0] lookup_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_rgb565;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Segment data leaving the stop store.
  typedef struct packed {
    rgb_t       ca;
    rgb_t       cb;
    logic [7:0] frac;
    logic       use_div;
    logic [7:0] pos;
    logic [7:0] p0;
    logic [7:0] p1;
  } seg_t;

  // Toned end colors travelling beside the divider.
  typedef struct packed {
    rgb_t       ta;
    rgb_t       tb;
    logic [7:0] frac;
    logic       use_div;
  } side_t;

  function automatic logic [7:0] tone(input logic [7:0] raw, input logic [7:0] knee,
                                      input logic [8:0] bright);
    logic [7:0]  v;
    logic [8:0]  br;
    logic [16:0] p;
    v = raw;
    if (raw > knee) begin
      v = knee + ((raw - knee) >> 2);
    end
    br = (bright > TONE_UNITY) ? TONE_UNITY : bright;
    p = {9'd0, v} * {8'd0, br};
    return (p[16:8] > {1'b0, CHAN_MAX}) ? CHAN_MAX : p[15:8];
  endfunction

endpackage

>>> sv/tgl_in_if.sv
// Input channel carrying load and lookup items.
interface tgl_in_if;
  import tgl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> sv/tgl_out_if.sv
// Output channel carrying result colors.
interface tgl_out_if;
  import tgl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> sv/tgl_stop_store.sv
// Stop storage with segment search, position repair and registered color reads.
module tgl_stop_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tgl_pkg::in_item_t item_i,
  input  tgl_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output tgl_pkg::seg_t   seg_o
);
  import tgl_pkg::*;

  logic [23:0]      col_mem [STOP_N];
  logic [7:0]       spos_q [STOP_N];
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] nm1;
  logic [7:0]       pos;
  logic [11:0]      scaled;
  logic [STOP_N-1:0] ge;
  logic             lo;
  logic             hi;
  logic [IDX_W-1:0] seg;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [7:0]       frac;
  logic             use_div;
  logic             wr;
  logic [7:0]       wr_pos;
  logic             valid_q;
  logic [7:0]       frac_q;
  logic             use_div_q;
  logic [7:0]       pos_q;
  logic [7:0]       p0_q;
  logic [7:0]       p1_q;
  logic [23:0]      rd_a_q;
  logic [23:0]      rd_b_q;

  always_comb begin
    if (cfg_i.stop_count < CNT_W'(2)) begin
      n = CNT_W'(2);
    end else if (cfg_i.stop_count > CNT_W'(STOP_N)) begin
      n = CNT_W'(STOP_N);
    end else begin
      n = cfg_i.stop_count;
    end
    nm1 = IDX_W'(n - CNT_W'(1));
    pos = cfg_i.reverse_ramp ? (CHAN_MAX - item_i.lookup_position) : item_i.lookup_position;
    scaled = {4'd0, pos} * {8'd0, nm1};

    for (int i = 0; i < STOP_N; i++) begin
      ge[i] = pos >= spos_q[i];
    end
    lo = pos <= spos_q[0];
    hi = pos >= spos_q[nm1];

    seg = nm1 - IDX_W'(1);
    for (int i = STOP_N - 2; i >= 1; i--) begin
      if (IDX_W'(i) < nm1 && !ge[i]) begin
        seg = IDX_W'(i - 1);
      end
    end

    use_div = 1'b0;
    frac = 8'd0;
    if (cfg_i.uniform_spacing) begin
      addr_a = scaled[11:8];
      addr_b = scaled[11:8] + IDX_W'(1);
      frac = scaled[7:0];
    end else if (lo) begin
      addr_a = '0;
      addr_b = '0;
    end else if (hi) begin
      addr_a = nm1;
      addr_b = nm1;
    end else begin
      addr_a = seg;
      addr_b = seg + IDX_W'(1);
      use_div = 1'b1;
    end

    wr = en_i && valid_i && (item_i.command == CMD_LOAD);
    wr_pos = item_i.stop_position;
    if (item_i.stop_index != '0 && item_i.stop_position < spos_q[item_i.stop_index - 4'd1]) begin
      wr_pos = spos_q[item_i.stop_index - 4'd1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      col_mem[item_i.stop_index] <= {item_i.stop_red, item_i.stop_green, item_i.stop_blue};
      spos_q[item_i.stop_index] <= wr_pos;
    end
    if (en_i) begin
      rd_a_q <= col_mem[addr_a];
      rd_b_q <= col_mem[addr_b];
      frac_q <= frac;
      use_div_q <= use_div;
      pos_q <= pos;
      p0_q <= spos_q[addr_a];
      p1_q <= spos_q[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && (item_i.command == CMD_LOOKUP);
    end
  end

  assign valid_o = valid_q;
  assign seg_o = '{ca: rd_a_q, cb: rd_b_q, frac: frac_q, use_div: use_div_q,
                   pos: pos_q, p0: p0_q, p1: p1_q};

endmodule

>>> sv/tgl_divider.sv
// Pipelined restoring divider giving the blend fraction of a segment.
module tgl_divider (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] pos_i,
  input  logic [7:0] p0_i,
  input  logic [7:0] p1_i,
  output logic [7:0] quot_o
);
  import tgl_pkg::*;

  logic [7:0] rem_q [DIV_STAGES];
  logic [7:0] den_q [DIV_STAGES];
  logic [7:0] quo_q [DIV_STAGES];
  logic [7:0] rem_d [DIV_STAGES];
  logic [7:0] den_d [DIV_STAGES];
  logic [7:0] quo_d [DIV_STAGES];

  always_comb begin
    logic [7:0] r;
    logic [7:0] dn;
    logic [7:0] qt;
    logic [8:0] sh;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        r = pos_i - p0_i;
        dn = p1_i - p0_i;
        qt = 8'd0;
      end else begin
        r = rem_q[s-1];
        dn = den_q[s-1];
        qt = quo_q[s-1];
      end
      for (int k = 0; k < DIV_BITS; k++) begin
        sh = {r, 1'b0};
        if (sh >= {1'b0, dn}) begin
          sh = sh - {1'b0, dn};
          qt = {qt[6:0], 1'b1};
        end else begin
          qt = {qt[6:0], 1'b0};
        end
        r = sh[7:0];
      end
      rem_d[s] = r;
      den_d[s] = dn;
      quo_d[s] = qt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

>>> sv/tgl_blend.sv
// Blend of two toned stops, ramp brightness, saturation and RGB565 packing.
module tgl_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tgl_pkg::rgb_t       ta_i,
  input  tgl_pkg::rgb_t       tb_i,
  input  logic [7:0]          frac_i,
  input  logic [9:0]          ramp_i,
  output logic                valid_o,
  output tgl_pkg::out_item_t  item_o
);
  import tgl_pkg::*;

  logic      bl_valid_q;
  rgb_t      bl_q;
  rgb_t      bl_d;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] f);
    logic [8:0]  d;
    logic [17:0] prod;
    d = {1'b0, b} - {1'b0, a};
    prod = {{9{d[8]}}, d} * {10'd0, f};
    return a + prod[15:8];
  endfunction

  function automatic logic [7:0] ramp(input logic [7:0] c, input logic [9:0] br);
    logic [17:0] v;
    v = {10'd0, c} * {8'd0, br};
    return (v[17:8] > {2'b0, CHAN_MAX}) ? CHAN_MAX : v[15:8];
  endfunction

  always_comb begin
    bl_d.r = mix(ta_i.r, tb_i.r, frac_i);
    bl_d.g = mix(ta_i.g, tb_i.g, frac_i);
    bl_d.b = mix(ta_i.b, tb_i.b, frac_i);
    out_d.red = ramp(bl_q.r, ramp_i);
    out_d.green = ramp(bl_q.g, ramp_i);
    out_d.blue = ramp(bl_q.b, ramp_i);
    out_d.pixel_rgb565 = {out_d.red[7:3], out_d.green[7:2], out_d.blue[7:3]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bl_q <= bl_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      bl_valid_q <= valid_i;
      out_valid_q <= bl_valid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o = out_q;

endmodule

>>> sv/theme_gradient_lookup_core.sv
// Top level of the multi-stop color gradient lookup pipeline.
//
//   Channel   Direction  Handshake          Payload
//   in_i      input      valid/ready        load or lookup item
//   out_o     output     valid/ready        red, green, blue, RGB565 pixel
//   cfg       input      cfg_we_i only      register index and write data
//
// One item can enter per cycle while out_o is not stalled, and its result is offered on out_o
// once the item has passed through every register of the path.
// The path is eight registers: input, stop read, four divider stages, blend and output.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
// Reset clears the valid bits and sets the configuration to its defaults; stops are undefined until loaded.
module theme_gradient_lookup_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tgl_in_if.sink                            in_i,
  tgl_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [tgl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tgl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tgl_pkg::*;

  cfg_t      cfg_q;
  logic      adv;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      seg_valid;
  seg_t      seg;
  logic      side_valid_q [DIV_STAGES];
  side_t     side_q [DIV_STAGES];
  side_t     side_d;
  logic [7:0] quot;
  logic [7:0] frac;
  logic      res_valid;
  out_item_t res_item;

  assign adv = !res_valid || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_TONE_BRIGHTNESS: cfg_q.tone_brightness <= cfg_data_i[8:0];
        REG_KNEE_LEVEL:      cfg_q.knee_level <= cfg_data_i[7:0];
        REG_RAMP_BRIGHTNESS: cfg_q.ramp_brightness <= cfg_data_i[9:0];
        REG_STOP_COUNT:      cfg_q.stop_count <= cfg_data_i[CNT_W-1:0];
        REG_UNIFORM_SPACING: cfg_q.uniform_spacing <= cfg_data_i[0];
        REG_REVERSE_RAMP:    cfg_q.reverse_ramp <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        side_valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      in_valid_q <= in_i.valid;
      side_valid_q[0] <= seg_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_valid_q[s] <= side_valid_q[s-1];
      end
    end
  end

  always_comb begin
    side_d.ta.r = tone(seg.ca.r, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.ta.g = tone(seg.ca.g, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.ta.b = tone(seg.ca.b, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.tb.r = tone(seg.cb.r, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.tb.g = tone(seg.cb.g, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.tb.b = tone(seg.cb.b, cfg_q.knee_level, cfg_q.tone_brightness);
    side_d.frac = seg.frac;
    side_d.use_div = seg.use_div;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_item_q <= in_i.data;
      side_q[0] <= side_d;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  tgl_stop_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_q),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .valid_o (seg_valid),
    .seg_o   (seg)
  );

  tgl_divider u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .pos_i  (seg.pos),
    .p0_i   (seg.p0),
    .p1_i   (seg.p1),
    .quot_o (quot)
  );

  assign frac = side_q[DIV_STAGES-1].use_div ? quot : side_q[DIV_STAGES-1].frac;

  tgl_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (side_valid_q[DIV_STAGES-1]),
    .ta_i    (side_q[DIV_STAGES-1].ta),
    .tb_i    (side_q[DIV_STAGES-1].tb),
    .frac_i  (frac),
    .ramp_i  (cfg_q.ramp_brightness),
    .valid_o (res_valid),
    .item_o  (res_item)
  );

  assign out_o.valid = res_valid;
  assign out_o.data = res_item;

endmodule
